@@ hdl/queue_lock_manager_defines.svh @@
// assertion macros for the queue lock manager
// used by queue_lock_manager.sv; no other dependencies
`ifndef QUEUE_LOCK_MANAGER_DEFINES_SVH
`define QUEUE_LOCK_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked property, disabled while reset is asserted
`define QLM_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("queue_lock_manager: assertion failed");

// checked property that also holds during reset
`define QLM_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("queue_lock_manager: assertion failed");

`else

`define QLM_ASSERT(lbl, ck, rn, prop)
`define QLM_ASSERT_ALWAYS(lbl, ck, prop)

`endif

`endif

@@ hdl/qlm_pkg.sv @@
// shared types and constants of the queue lock manager
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package qlm_pkg;

	localparam int TID_W    = 7;
	localparam int LOCK_W   = 8;
	localparam int STATUS_W = 3;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_GRANTED    = 3'd0,
		STAT_QUEUED     = 3'd1,
		STAT_FREED      = 3'd2,
		STAT_PASSED     = 3'd3,
		STAT_NO_SLOT    = 3'd4,
		STAT_NOT_HOLDER = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_DEC,
		FSM_LINK,
		FSM_REL,
		FSM_PASS
	} fsm_t;

	typedef struct packed {
		status_t           status;
		logic              own_slot;
		logic              grant_valid;
		logic [TID_W-1:0]  grant_thread;
		logic              grant_slot;
	} rsp_t;

endpackage

`default_nettype wire

@@ hdl/qlm_req_if.sv @@
// request channel of the queue lock manager: valid/ready plus request word
// depends on qlm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qlm_req_if;
	import qlm_pkg::*;

	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [TID_W-1:0]  thread_id;
	logic [LOCK_W-1:0] lock_id;

	modport source (output valid, cmd, thread_id, lock_id, input ready);
	modport sink (input valid, cmd, thread_id, lock_id, output ready);
endinterface

`default_nettype wire

@@ hdl/qlm_rsp_if.sv @@
// response channel of the queue lock manager: valid/ready plus result word
// depends on qlm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qlm_rsp_if;
	import qlm_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic             own_slot;
	logic             grant_valid;
	logic [TID_W-1:0] grant_thread;
	logic             grant_slot;

	modport source (output valid, status, own_slot, grant_valid, grant_thread, grant_slot,
		input ready);
	modport sink (input valid, status, own_slot, grant_valid, grant_thread, grant_slot,
		output ready);
endinterface

`default_nettype wire

@@ hdl/queue_lock_manager.sv @@
// queue lock manager top level: lock tail, link and slot tables in synchronous memories
// depends on qlm_pkg, qlm_req_if, qlm_rsp_if and queue_lock_manager_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "queue_lock_manager_defines.svh"

// Hardware FIFO lock manager. Each request word (acquire or release of one lock by one
// thread) yields exactly one result word. A request is handled by a short sequencer over
// four synchronous memories (lock tail, slot link, per-thread held locks, per-thread wait
// bits), each with a registered read port. An acquire that is granted at once and any error
// finish in the decode state, an acquire that queues goes on to the link state, a release
// that frees the lock goes on to the release state and a release that passes it to a waiter
// goes on through the release and pass states; the path is set by the chain of dependent
// memory reads (slot row, then link entry, then the waiter's row). The result sits in an
// output register, so the next request is accepted while it waits. After reset a clearing
// sweep over max(NUM_LOCKS, LINK_DEPTH) addresses (256 at the defaults) runs with ready low.
module queue_lock_manager #(
	parameter int MAX_THREADS      = 128,
	parameter int SLOTS_PER_THREAD = 2,
	parameter int NUM_LOCKS        = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	qlm_req_if.sink   req,
	qlm_rsp_if.source rsp
);
	import qlm_pkg::*;

	localparam int TW          = $clog2(MAX_THREADS);
	localparam int SLW         = (SLOTS_PER_THREAD > 1) ? $clog2(SLOTS_PER_THREAD) : 1;
	localparam int LKW         = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int SIW         = TW + SLW;
	localparam int LINK_DEPTH  = MAX_THREADS * (2 ** SLW);
	localparam int CLR_DEPTH   = (NUM_LOCKS > LINK_DEPTH) ? NUM_LOCKS : LINK_DEPTH;
	localparam int CNTW        = $clog2(CLR_DEPTH);

	// tail and link entry layout: {valid, thread, slot}
	logic [SIW:0]                         tail_mem [NUM_LOCKS];
	logic [SIW:0]                         next_mem [LINK_DEPTH];
	logic [SLOTS_PER_THREAD-1:0][LKW:0]   held_mem [MAX_THREADS];
	logic [SLOTS_PER_THREAD-1:0]          wait_mem [MAX_THREADS];

	logic [SIW:0]                         tail_rd_q;
	logic [SIW:0]                         next_rd_q;
	logic [SLOTS_PER_THREAD-1:0][LKW:0]   held_rd_q;
	logic [SLOTS_PER_THREAD-1:0]          wait_rd_q;

	logic                                 tail_we, next_we, held_we, wait_we;
	logic                                 tail_re, next_re, held_re, wait_re;
	logic [LKW-1:0]                       tail_wa, tail_ra;
	logic [SIW-1:0]                       next_wa, next_ra;
	logic [TW-1:0]                        held_wa, held_ra, wait_wa, wait_ra;
	logic [SIW:0]                         tail_wd, next_wd;
	logic [SLOTS_PER_THREAD-1:0][LKW:0]   held_wd;
	logic [SLOTS_PER_THREAD-1:0]          wait_wd;

	fsm_t            fsm_q, fsm_d;
	logic [CNTW-1:0] cnt_q;
	cmd_t            cmd_q;
	logic [TW-1:0]   tid_q;
	logic [LKW-1:0]  lk_q;
	logic            bad_q;
	logic [SLW-1:0]  slot_q;
	rsp_t            out_q;
	logic            out_valid_q;

	logic            accept;
	logic            done;
	logic            stall;
	rsp_t            res;
	logic            acq_found, rel_found;
	logic [SLW-1:0]  acq_slot, rel_slot;
	logic            any_we;
	logic            out_pass;
	logic            out_err;

	assign req.ready = (fsm_q == FSM_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.own_slot     = out_q.own_slot;
	assign rsp.grant_valid  = out_q.grant_valid;
	assign rsp.grant_thread = out_q.grant_thread;
	assign rsp.grant_slot   = out_q.grant_slot;

	// slot search over the requester's row; lowest index wins
	always_comb begin
		acq_found = 1'b0;
		acq_slot  = '0;
		rel_found = 1'b0;
		rel_slot  = '0;
		for (int i = SLOTS_PER_THREAD - 1; i >= 0; i--) begin
			if (!held_rd_q[i][LKW]) begin
				acq_found = 1'b1;
				acq_slot  = SLW'(i);
			end
			if (held_rd_q[i][LKW] && held_rd_q[i][LKW-1:0] == lk_q && !wait_rd_q[i]) begin
				rel_found = 1'b1;
				rel_slot  = SLW'(i);
			end
		end
	end

	// next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FSM_CLEAR: begin
				if (cnt_q == CNTW'(CLR_DEPTH - 1))
					fsm_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (accept)
					fsm_d = FSM_DEC;
			end
			FSM_DEC: begin
				if (!stall) begin
					if (done)
						fsm_d = FSM_IDLE;
					else if (cmd_q == CMD_ACQUIRE)
						fsm_d = FSM_LINK;
					else
						fsm_d = FSM_REL;
				end
			end
			FSM_LINK: begin
				if (!stall)
					fsm_d = FSM_IDLE;
			end
			FSM_REL: begin
				if (!stall)
					fsm_d = done ? FSM_IDLE : FSM_PASS;
			end
			FSM_PASS: begin
				if (!stall)
					fsm_d = FSM_IDLE;
			end
			default: fsm_d = FSM_CLEAR;
		endcase
	end

	// memory controls and result
	always_comb begin
		done    = 1'b0;
		res     = '0;
		tail_we = 1'b0;
		next_we = 1'b0;
		held_we = 1'b0;
		wait_we = 1'b0;
		tail_re = 1'b0;
		next_re = 1'b0;
		held_re = 1'b0;
		wait_re = 1'b0;
		tail_wa = lk_q;
		tail_ra = LKW'(req.lock_id);
		next_wa = {tid_q, slot_q};
		next_ra = {tid_q, rel_slot};
		held_wa = tid_q;
		held_ra = TW'(req.thread_id);
		wait_wa = tid_q;
		wait_ra = TW'(req.thread_id);
		tail_wd = '0;
		next_wd = '0;
		held_wd = held_rd_q;
		wait_wd = wait_rd_q;
		unique case (fsm_q)
			FSM_CLEAR: begin
				tail_we = 32'(cnt_q) < NUM_LOCKS;
				tail_wa = cnt_q[LKW-1:0];
				next_we = 1'b1;
				next_wa = cnt_q[SIW-1:0];
				held_we = 32'(cnt_q) < MAX_THREADS;
				held_wa = cnt_q[TW-1:0];
				held_wd = '0;
				wait_we = 32'(cnt_q) < MAX_THREADS;
				wait_wa = cnt_q[TW-1:0];
				wait_wd = '0;
			end
			FSM_IDLE: begin
				tail_re = accept;
				held_re = accept;
				wait_re = accept;
			end
			FSM_DEC: begin
				if (bad_q) begin
					done       = 1'b1;
					res.status = (cmd_q == CMD_RELEASE) ? STAT_NOT_HOLDER : STAT_NO_SLOT;
				end else if (cmd_q == CMD_ACQUIRE) begin
					if (!acq_found) begin
						done       = 1'b1;
						res.status = STAT_NO_SLOT;
					end else begin
						held_we           = 1'b1;
						held_wd[acq_slot] = {1'b1, lk_q};
						wait_we           = 1'b1;
						wait_wd[acq_slot] = tail_rd_q[SIW];
						tail_we           = 1'b1;
						tail_wd           = {1'b1, tid_q, acq_slot};
						next_we           = 1'b1;
						next_wa           = {tid_q, acq_slot};
						// empty queue: granted now, else link behind the old tail in the link state
						if (!tail_rd_q[SIW]) begin
							done         = 1'b1;
							res.status   = STAT_GRANTED;
							res.own_slot = acq_slot[0];
						end
					end
				end else begin
					if (!rel_found) begin
						done       = 1'b1;
						res.status = STAT_NOT_HOLDER;
					end else begin
						next_re = 1'b1;
					end
				end
			end
			FSM_LINK: begin
				done         = 1'b1;
				res.status   = STAT_QUEUED;
				res.own_slot = slot_q[0];
				next_we      = 1'b1;
				next_wa      = tail_rd_q[SIW-1:0];
				next_wd      = {1'b1, tid_q, slot_q};
			end
			FSM_REL: begin
				held_we         = 1'b1;
				held_wd[slot_q] = '0;
				next_we         = 1'b1;
				if (next_rd_q[SIW]) begin
					// fetch the successor's wait row to clear its bit
					wait_re = 1'b1;
					wait_ra = next_rd_q[SIW-1:SLW];
				end else begin
					done         = 1'b1;
					res.status   = STAT_FREED;
					res.own_slot = slot_q[0];
					if (tail_rd_q == {1'b1, tid_q, slot_q})
						tail_we = 1'b1;
				end
			end
			FSM_PASS: begin
				done                          = 1'b1;
				res.status                    = STAT_PASSED;
				res.own_slot                  = slot_q[0];
				res.grant_valid               = 1'b1;
				res.grant_thread              = TID_W'(next_rd_q[SIW-1:SLW]);
				res.grant_slot                = next_rd_q[0];
				wait_we                       = 1'b1;
				wait_wa                       = next_rd_q[SIW-1:SLW];
				wait_wd[next_rd_q[SLW-1:0]]   = 1'b0;
			end
			default: begin
				done = 1'b0;
			end
		endcase
		// hold the final step until the output register is free
		stall = done && out_valid_q && !rsp.ready;
		if (stall) begin
			tail_we = 1'b0;
			next_we = 1'b0;
			held_we = 1'b0;
			wait_we = 1'b0;
			tail_re = 1'b0;
			next_re = 1'b0;
			held_re = 1'b0;
			wait_re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= FSM_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == FSM_CLEAR)
				cnt_q <= cnt_q + CNTW'(1);
			if (done && !stall)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			tid_q <= TW'(req.thread_id);
			lk_q  <= LKW'(req.lock_id);
			bad_q <= !(32'(req.thread_id) < MAX_THREADS && 32'(req.lock_id) < NUM_LOCKS);
		end
		if (fsm_q == FSM_DEC)
			slot_q <= (cmd_q == CMD_ACQUIRE) ? acq_slot : rel_slot;
		if (done && !stall)
			out_q <= res;
	end

	always_ff @(posedge clk) begin
		if (tail_we)
			tail_mem[tail_wa] <= tail_wd;
		if (tail_re)
			tail_rd_q <= tail_mem[tail_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa] <= next_wd;
		if (next_re)
			next_rd_q <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (held_we)
			held_mem[held_wa] <= held_wd;
		if (held_re)
			held_rd_q <= held_mem[held_ra];
	end

	always_ff @(posedge clk) begin
		if (wait_we)
			wait_mem[wait_wa] <= wait_wd;
		if (wait_re)
			wait_rd_q <= wait_mem[wait_ra];
	end

	assign any_we   = tail_we || next_we || held_we || wait_we;
	assign out_pass = (out_q.status == STAT_PASSED);
	assign out_err  = (out_q.status == STAT_NO_SLOT || out_q.status == STAT_NOT_HOLDER);

	`QLM_ASSERT_ALWAYS(a_reset_clears, clk, !arst_n |=> fsm_q == FSM_CLEAR)
	`QLM_ASSERT(a_accept_decode, clk, arst_n, accept |=> fsm_q == FSM_DEC)
	`QLM_ASSERT(a_idle_no_write, clk, arst_n, fsm_q == FSM_IDLE |-> !any_we)
	`QLM_ASSERT(a_link_has_pred, clk, arst_n, fsm_q == FSM_LINK |-> tail_rd_q[SIW])
	`QLM_ASSERT(a_grant_on_pass, clk, arst_n, out_valid_q |-> out_q.grant_valid == out_pass)
	`QLM_ASSERT(a_error_clean, clk, arst_n, out_valid_q && out_err |-> !out_q.own_slot && !out_q.grant_valid)

endmodule

`default_nettype wire

@@ test/tb_queue_lock_manager.sv @@
// self-checking testbench for queue_lock_manager: directed and random acquire/release traffic
// compares every result word against an in-bench model of the lock queues
// depends on qlm_pkg, qlm_req_if, qlm_rsp_if and the queue_lock_manager rtl
`timescale 1ns / 1ps

module tb_queue_lock_manager;
	import qlm_pkg::*;

	localparam int THREADS     = 128;
	localparam int SLOTS       = 2;
	localparam int LOCKS       = 256;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 16;

	typedef struct packed {
		cmd_t              cmd;
		logic [TID_W-1:0]  thread_id;
		logic [LOCK_W-1:0] lock_id;
	} lock_req_t;

	logic clk;
	logic arst_n;

	qlm_req_if req();
	qlm_rsp_if rsp();

	queue_lock_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// model state: bit 8 is the valid flag, bits 7:0 a slot index or lock id
	logic [8:0] tail_of_lock [LOCKS] = '{default: '0};
	logic [8:0] next_of_slot [THREADS*SLOTS] = '{default: '0};
	logic [8:0] lock_of_slot [THREADS*SLOTS] = '{default: '0};
	bit         slot_waits [THREADS*SLOTS] = '{default: 1'b0};

	lock_req_t pending_reqs [$];
	rsp_t      due_results [$];

	int  send_idle;
	int  recv_stall;
	bit  word_taken;
	int  fail_count;
	int  words_sent;
	int  words_checked;
	int  cycles;
	int  status_seen [6];
	rsp_t want;

	always #5 clk = ~clk;

	// applies one request to the model lock queues and returns the expected result word
	function automatic rsp_t settle_request(input lock_req_t w);
		rsp_t       r;
		int         base;
		int         s;
		int         me;
		int         succ;
		bit         found;
		logic [8:0] pred;
		r = '0;
		r.status = STAT_GRANTED;
		found = 1'b0;
		s = 0;
		base = int'(w.thread_id) * SLOTS;
		if (int'(w.thread_id) >= THREADS || int'(w.lock_id) >= LOCKS) begin
			r.status = (w.cmd == CMD_RELEASE) ? STAT_NOT_HOLDER : STAT_NO_SLOT;
			return r;
		end
		if (w.cmd == CMD_ACQUIRE) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && !lock_of_slot[base+i][8]) begin
					s = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = STAT_NO_SLOT;
				return r;
			end
			me = base + s;
			next_of_slot[me] = '0;
			lock_of_slot[me] = {1'b1, w.lock_id};
			pred = tail_of_lock[w.lock_id];
			tail_of_lock[w.lock_id] = {1'b1, 8'(me)};
			r.own_slot = s[0];
			if (!pred[8]) begin
				slot_waits[me] = 1'b0;
				r.status = STAT_GRANTED;
			end else begin
				slot_waits[me] = 1'b1;
				next_of_slot[pred[7:0]] = {1'b1, 8'(me)};
				r.status = STAT_QUEUED;
			end
			return r;
		end
		// a waiting slot does not count as holding
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && lock_of_slot[base+i] == {1'b1, w.lock_id} && !slot_waits[base+i]) begin
				s = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			r.status = STAT_NOT_HOLDER;
			return r;
		end
		me = base + s;
		lock_of_slot[me] = '0;
		r.own_slot = s[0];
		if (next_of_slot[me][8]) begin
			succ = int'(next_of_slot[me][7:0]);
			next_of_slot[me] = '0;
			slot_waits[succ] = 1'b0;
			r.status = STAT_PASSED;
			r.grant_valid = 1'b1;
			r.grant_thread = 7'(succ / SLOTS);
			r.grant_slot = 1'(succ % SLOTS);
			return r;
		end
		next_of_slot[me] = '0;
		if (tail_of_lock[w.lock_id] == {1'b1, 8'(me)})
			tail_of_lock[w.lock_id] = '0;
		r.status = STAT_FREED;
		return r;
	endfunction

	function automatic lock_req_t lock_word(input cmd_t c, input int tid, input int lk);
		lock_req_t w;
		w.cmd = c;
		w.thread_id = TID_W'(tid);
		w.lock_id = LOCK_W'(lk);
		return w;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// contended traffic over a small crew of threads and locks, plus some random words over all
	// ids; releases go to the oldest open acquire of a lock, in fifo order its current holder
	task automatic queue_random_traffic(input int count);
		logic [TID_W-1:0]  crew [6];
		logic [LOCK_W-1:0] locks [4];
		lock_req_t         open_acq [$];
		lock_req_t         w;
		int                pick;
		int                r;
		bit                hit;
		for (int i = 0; i < 6; i++)
			crew[i] = TID_W'($urandom_range(THREADS-1));
		for (int i = 0; i < 4; i++)
			locks[i] = LOCK_W'($urandom_range(LOCKS-1));
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 10) begin
				w.cmd = $urandom_range(1) ? CMD_RELEASE : CMD_ACQUIRE;
				w.thread_id = TID_W'($urandom_range(THREADS-1));
				w.lock_id = LOCK_W'($urandom_range(LOCKS-1));
				if (w.cmd == CMD_ACQUIRE)
					open_acq.push_back(w);
			end else if (open_acq.size() == 0 || (open_acq.size() < 10 && r < 55)) begin
				w.cmd = CMD_ACQUIRE;
				w.thread_id = crew[$urandom_range(5)];
				w.lock_id = locks[$urandom_range(3)];
				open_acq.push_back(w);
			end else begin
				pick = $urandom_range(open_acq.size() - 1);
				hit = 1'b0;
				for (int k = 0; k < open_acq.size(); k++) begin
					if (!hit && open_acq[k].lock_id == open_acq[pick].lock_id) begin
						pick = k;
						hit = 1'b1;
					end
				end
				w = open_acq[pick];
				w.cmd = CMD_RELEASE;
				open_acq.delete(pick);
			end
			pending_reqs.push_back(w);
		end
		// leave every lock free for the next phase
		while (open_acq.size() != 0) begin
			w = open_acq.pop_front();
			w.cmd = CMD_RELEASE;
			pending_reqs.push_back(w);
		end
	endtask

	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || due_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || word_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
				req.valid <= 1'b1;
				req.cmd <= pending_reqs[0].cmd;
				req.thread_id <= pending_reqs[0].thread_id;
				req.lock_id <= pending_reqs[0].lock_id;
			end else begin
				req.valid <= 1'b0;
			end
		end
		word_taken = 1'b0;
		rsp.ready <= ($urandom_range(99) >= recv_stall);
	end

	// monitor: accepted requests feed the model, accepted results are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				due_results.push_back(settle_request(pending_reqs.pop_front()));
				word_taken = 1'b1;
				words_sent++;
			end
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with nothing outstanding: status %0d", rsp.status);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("status", int'(want.status), int'(rsp.status));
					check_field("own_slot", int'(want.own_slot), int'(rsp.own_slot));
					check_field("grant_valid", int'(want.grant_valid), int'(rsp.grant_valid));
					check_field("grant_thread", int'(want.grant_thread), int'(rsp.grant_thread));
					check_field("grant_slot", int'(want.grant_slot), int'(rsp.grant_slot));
					status_seen[int'(want.status)]++;
					words_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles,
				due_results.size() + pending_reqs.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_ACQUIRE;
		req.thread_id = '0;
		req.lock_id = '0;
		rsp.ready = 1'b0;
		word_taken = 1'b0;
		fail_count = 0;
		words_sent = 0;
		words_checked = 0;
		cycles = 0;
		send_idle = 29;
		recv_stall = 68;

		// handoff, waiter release, slot exhaustion, extremes of thread and lock
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 0, 0));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 127, 0));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 127, 0));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 127, 255));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 127, 1));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 0, 0));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 127, 0));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 127, 255));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 127, 255));
		// holder queues behind itself
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 85, 170));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 85, 170));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 85, 170));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 85, 170));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 85, 170));
		// three deep queue handed down the line
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 42, 85));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 127, 85));
		pending_reqs.push_back(lock_word(CMD_ACQUIRE, 0, 85));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 42, 85));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 127, 85));
		pending_reqs.push_back(lock_word(CMD_RELEASE, 0, 85));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_random_traffic(230);
		wait_quiet();
		send_idle = 68;
		recv_stall = 29;
		queue_random_traffic(230);
		wait_quiet();
		send_idle = 0;
		recv_stall = 0;
		queue_random_traffic(230);
		wait_quiet();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d requests sent over three handshake phases, %0d result words checked",
			words_sent, words_checked);
		$display("granted %0d, queued %0d, freed %0d, passed %0d, no slot %0d, not holder %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5]);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/qlm_pkg.sv
hdl/qlm_req_if.sv
hdl/qlm_rsp_if.sv
hdl/queue_lock_manager.sv
test/tb_queue_lock_manager.sv
